[hw/rtl/etdcb_pkg.sv]
`default_nettype none

package etdcb_pkg;

  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 32;
  localparam int TIME_W   = 32;
  localparam int MASK_W   = 32;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TICK    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ    = 3'd4;

  typedef struct packed {
    logic                      used;
    logic [KEY_W-1:0]          key;
    logic signed [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [KEY_W-1:0]          key;
    logic signed [COUNT_W-1:0] count;
    logic [TIME_W-1:0]         dt;
    logic                      skip;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic expired;
  } head_flags_t;

endpackage

`default_nettype wire

[hw/rtl/elapsed_time_down_counter_bank.sv]
// Channel   Handshake            Fields
// input     start / busy         mode, counter_key, start_count, now_time
// result    done (strobe)        status, count_value, is_active, expired_mask,
//                                tick_skipped
//
// Each word goes from acceptance through the shift and finish states to the
// done strobe: the slot entries rotate once around the ring of cells, one
// entry through the head per cycle, then the finish state writes the slot and
// registers the result. busy is high from acceptance until the strobe; a new
// word may be accepted in the strobe cycle, but not while one is in progress.
// Reset frees all slots and clears the last time.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module elapsed_time_down_counter_bank
  import etdcb_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [MODE_W-1:0]         mode,
  input  wire logic [KEY_W-1:0]          counter_key,
  input  wire logic signed [COUNT_W-1:0] start_count,
  input  wire logic [TIME_W-1:0]         now_time,
  output logic                           done,
  output logic [STATUS_W-1:0]            status,
  output logic signed [COUNT_W-1:0]      count_value,
  output logic                           is_active,
  output logic [MASK_W-1:0]              expired_mask,
  output logic                           tick_skipped
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SHIFT  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                    state;
  state_t                    state_next;
  cmd_t                      cmd;
  logic [TIME_W-1:0]         last_time;
  logic [IDX_W-1:0]          step;
  logic                      hit;
  logic signed [COUNT_W-1:0] hit_count;
  logic                      free_found;
  logic [IDX_W-1:0]          free_idx;
  logic [MASK_W-1:0]         mask;

  entry_t      ent [SLOTS];
  entry_t      head_out;
  entry_t      new_entry;
  head_flags_t flags;
  logic        accept;
  logic        shifting;
  logic        do_add;
  logic [TIME_W-1:0] dt;
  logic [31:0] step_ext;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign shifting = (state == S_SHIFT);
  assign dt       = now_time - last_time;
  assign step_ext = 32'(step);
  assign do_add   = (state == S_FINISH) && (cmd.mode == MODE_START) && !hit &&
                    free_found;

  assign new_entry.used  = 1'b1;
  assign new_entry.key   = cmd.key;
  assign new_entry.count = cmd.count;

  etdcb_head u_head (
    .cmd       (cmd),
    .entry_in  (ent[0]),
    .entry_out (head_out),
    .flags     (flags)
  );

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    entry_t link;
    if (k == SLOTS - 1) begin : g_last
      assign link = head_out;
    end else begin : g_mid
      assign link = ent[k+1];
    end
    etdcb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shifting),
      .shift_in (link),
      .wr_en    (do_add && (free_idx == IDX_W'(k))),
      .wr_data  (new_entry),
      .entry    (ent[k])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (step == IDX_W'(SLOTS - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_time <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
      if (accept && (mode == MODE_TICK)) begin
        last_time <= now_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.mode   <= mode;
      cmd.key    <= counter_key;
      cmd.count  <= start_count;
      cmd.dt     <= dt;
      cmd.skip   <= (mode == MODE_TICK) ? ((dt == '0) || (last_time == '0)) : 1'b1;
      step       <= '0;
      hit        <= 1'b0;
      hit_count  <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
      mask       <= '0;
    end else if (shifting) begin
      step <= step + 1'b1;
      if (flags.hit) begin
        hit       <= 1'b1;
        hit_count <= ent[0].count;
      end
      if (flags.free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= step;
      end
      if (flags.expired && (step_ext < 32'(MASK_W))) begin
        mask[step_ext[4:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      count_value  <= '0;
      is_active    <= 1'b0;
      expired_mask <= '0;
      tick_skipped <= 1'b0;
      case (cmd.mode)
        MODE_START: begin
          if (hit) begin
            status <= ST_UPDATED;
          end else if (free_found) begin
            status <= ST_ADDED;
          end else begin
            status <= ST_FULL;
          end
        end
        MODE_TICK: begin
          status       <= ST_TICK;
          expired_mask <= mask;
          tick_skipped <= cmd.skip;
        end
        MODE_READ: begin
          status      <= ST_READ;
          count_value <= hit ? hit_count : '0;
          is_active   <= hit;
        end
        default: begin
          status       <= ST_TICK;
          tick_skipped <= 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("State register is not one-hot.");

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH))
    else $error("Result strobe without a finishing cycle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("Accepted word did not make the block busy.");

  a_add_has_room: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_ADDED)) |-> $past(free_found && !hit))
    else $error("Counter added without a free slot.");
`endif

endmodule

`default_nettype wire

[hw/rtl/etdcb_cell.sv]
`default_nettype none

module etdcb_cell
  import etdcb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift_en,
  input  entry_t shift_in,
  input  logic   wr_en,
  input  entry_t wr_data,
  output entry_t entry
);

  logic                      used;
  logic [KEY_W-1:0]          key;
  logic signed [COUNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (wr_en) begin
      used <= wr_data.used;
    end else if (shift_en) begin
      used <= shift_in.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key   <= wr_data.key;
      count <= wr_data.count;
    end else if (shift_en) begin
      key   <= shift_in.key;
      count <= shift_in.count;
    end
  end

  assign entry.used  = used;
  assign entry.key   = key;
  assign entry.count = count;

endmodule

`default_nettype wire

[hw/rtl/etdcb_head.sv]
`default_nettype none

module etdcb_head
  import etdcb_pkg::*;
(
  input  cmd_t        cmd,
  input  entry_t      entry_in,
  output entry_t      entry_out,
  output head_flags_t flags
);

  logic key_match;
  logic tick_on;
  logic expire;

  assign key_match = entry_in.used && (entry_in.key == cmd.key);
  assign tick_on   = (cmd.mode == MODE_TICK) && !cmd.skip;
  assign expire    = entry_in.count[COUNT_W-1] || (entry_in.count == '0) ||
                     (COUNT_W'(unsigned'(entry_in.count)) <= cmd.dt);

  always_comb begin
    entry_out     = entry_in;
    flags.hit     = 1'b0;
    flags.free    = !entry_in.used;
    flags.expired = 1'b0;
    case (cmd.mode)
      MODE_START: begin
        flags.hit = key_match;
        if (key_match) begin
          entry_out.count = cmd.count;
        end
      end
      MODE_TICK: begin
        if (tick_on && entry_in.used) begin
          if (expire) begin
            entry_out.used  = 1'b0;
            entry_out.count = '0;
            flags.expired   = 1'b1;
          end else begin
            entry_out.count = entry_in.count - $signed(cmd.dt);
          end
        end
      end
      MODE_READ: begin
        flags.hit = key_match;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
